// ----- rtl/core/utf16_to_utf8_encoder_top_defines.svh -----
// Assertion helpers for the checker file.
`ifndef UTF16_TO_UTF8_ENCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define U16U8_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u16u8 check failed");

// Next-cycle implication, off during reset.
`define U16U8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u16u8 check failed");

`endif

// ----- rtl/core/u16u8_pkg.sv -----
`default_nettype none
package u16u8_pkg;

  localparam int JOB_BYTES = 6;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  localparam logic [15:0] HI_FIRST = 16'hD800;
  localparam logic [15:0] HI_LAST  = 16'hDBFF;
  localparam logic [15:0] LO_FIRST = 16'hDC00;
  localparam logic [15:0] LO_LAST  = 16'hDFFF;

  // Plane offset 0x10000 expressed in units of 1024 code points.
  localparam logic [10:0] PLANE_OFS = 11'd64;

  // One input item's worth of output bytes, first byte at index 0.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                cnt;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic [2:0][7:0] b;
    logic [1:0]      n;
  } bmp_t;

  function automatic bmp_t enc_bmp(input logic [15:0] u);
    bmp_t r;
    r = '0;
    if (u[15:7] == 9'd0) begin
      r.b[0] = {1'b0, u[6:0]};
      r.n    = 2'd1;
    end else if (u[15:11] == 5'd0) begin
      r.b[0] = {3'b110, u[10:6]};
      r.b[1] = {2'b10, u[5:0]};
      r.n    = 2'd2;
    end else begin
      r.b[0] = {4'b1110, u[15:12]};
      r.b[1] = {2'b10, u[11:6]};
      r.b[2] = {2'b10, u[5:0]};
      r.n    = 2'd3;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/u16u8_front.sv -----
`default_nettype none
module u16u8_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [15:0]   code_unit,
  input  wire logic          last_unit,
  output u16u8_pkg::job_t    job,
  output logic               job_push
);
  import u16u8_pkg::*;

  logic        holding;
  logic        holding_next;
  logic [9:0]  held;
  logic        is_high;
  logic        is_low;
  logic        keep_new;
  logic        paired;
  bmp_t        new_enc;
  bmp_t        held_enc;
  logic [10:0] hi_part;
  logic [20:0] cp;

  assign is_high  = (code_unit >= HI_FIRST) && (code_unit <= HI_LAST);
  assign is_low   = (code_unit >= LO_FIRST) && (code_unit <= LO_LAST);
  assign keep_new = is_high && !last_unit;
  assign paired   = holding && is_low;

  assign new_enc  = enc_bmp(code_unit);
  assign held_enc = enc_bmp({HI_FIRST[15:10], held});
  assign hi_part  = {1'b0, held} + PLANE_OFS;
  assign cp       = {hi_part, code_unit[9:0]};

  always_comb begin
    job      = '0;
    job.last = last_unit;
    if (paired) begin
      job.bytes[0] = {5'b11110, cp[20:18]};
      job.bytes[1] = {2'b10, cp[17:12]};
      job.bytes[2] = {2'b10, cp[11:6]};
      job.bytes[3] = {2'b10, cp[5:0]};
      job.cnt      = 3'd4;
    end else begin
      // unpaired held surrogate goes out first as 3 bytes
      if (holding) begin
        job.bytes[2:0] = held_enc.b;
        job.cnt        = {1'b0, held_enc.n};
      end
      if (!keep_new) begin
        if (holding) begin
          job.bytes[5:3] = new_enc.b;
        end else begin
          job.bytes[2:0] = new_enc.b;
        end
        job.cnt = job.cnt + {1'b0, new_enc.n};
      end
    end
  end

  assign job_push     = take && (job.cnt != 3'd0);
  assign holding_next = keep_new && !paired;

  always_ff @(posedge clk) begin
    if (rst) begin
      holding <= 1'b0;
    end else if (take) begin
      holding <= holding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && holding_next) begin
      held <= code_unit[9:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/u16u8_queue.sv -----
`default_nettype none
module u16u8_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire u16u8_pkg::job_t  push_job,
  output logic                  full,
  input  wire logic             pop,
  output u16u8_pkg::job_t       head_job,
  output logic                  head_valid
);
  import u16u8_pkg::*;

  job_t            entry [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/u16u8_back.sv -----
`default_nettype none
module u16u8_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire u16u8_pkg::job_t head_job,
  input  wire logic            head_valid,
  output logic                 pop,
  output logic                 byte_valid,
  input  wire logic            byte_stall,
  output logic [7:0]           out_byte,
  output logic                 run_end,
  output logic                 string_end
);
  import u16u8_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       out_free;
  logic       adv;
  logic       cur_final;
  logic       finishing;

  assign out_free  = !byte_valid || !byte_stall;
  assign adv       = cur_valid && out_free;
  assign cur_final = (idx == (cur.cnt - 3'd1));
  assign finishing = adv && cur_final;
  assign pop       = head_valid && (!cur_valid || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (finishing) begin
      cur_valid <= 1'b0;
    end else if (adv) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_job;
    end
  end

  // output register decouples the byte stream from the stall input
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (adv) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte   <= cur.bytes[idx[2:0]];
      run_end    <= cur_final;
      string_end <= cur_final && cur.last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/utf16_to_utf8_encoder_top.sv -----
`default_nettype none
// UTF-16 to UTF-8 encoder. One code unit per transfer on the unit channel,
// one UTF-8 byte per transfer on the byte channel. A unit is taken in every
// cycle while the four-entry job queue between the classifier and the byte
// serializer has room; the serializer sends one byte per cycle while
// byte_stall is low. An item yields 1 to 3 bytes for a BMP unit, 4 for
// a surrogate pair, up to 6 when a held high surrogate is flushed ahead of
// the next unit, and none for a high surrogate held for pairing. run_end
// marks the last byte of each queued job's output, string_end the last byte
// of the string. Unpaired surrogates come out as 3-byte sequences.
module utf16_to_utf8_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        unit_valid,
  output logic             unit_stall,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  output logic             byte_valid,
  input  wire logic        byte_stall,
  output logic [7:0]       out_byte,
  output logic             run_end,
  output logic             string_end
);
  import u16u8_pkg::*;

  job_t job;
  job_t head_job;
  logic job_push;
  logic q_full;
  logic head_valid;
  logic pop;
  logic take;

  assign unit_stall = q_full;
  assign take       = unit_valid && !q_full;

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .job       (job),
    .job_push  (job_push)
  );

  u16u8_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (job),
    .full       (q_full),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .string_end (string_end)
  );

endmodule
`default_nettype wire

// ----- rtl/core/u16u8_chk.sv -----
`default_nettype none
`include "utf16_to_utf8_encoder_top_defines.svh"
module u16u8_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        unit_valid,
  input wire logic        unit_stall,
  input wire logic [15:0] code_unit,
  input wire logic        last_unit,
  input wire logic        byte_valid,
  input wire logic        byte_stall,
  input wire logic [7:0]  out_byte,
  input wire logic        run_end,
  input wire logic        string_end
);

  // stalled unit holds
  `U16U8_ASSERT_NEXT(a_unit_hold, unit_valid && unit_stall, unit_valid && $stable({code_unit, last_unit}))

  // stalled byte holds
  `U16U8_ASSERT_NEXT(a_hold, byte_valid && byte_stall, byte_valid && $stable({out_byte, run_end, string_end}))

  // string end only closes a run
  `U16U8_ASSERT_NOW(a_end_run, byte_valid && string_end, run_end)

  // a run continues without a gap
  `U16U8_ASSERT_NEXT(a_cont, byte_valid && !byte_stall && !run_end, byte_valid)

  // a run never ends on a lead byte of a multibyte form
  `U16U8_ASSERT_NOW(a_lead, byte_valid && run_end, out_byte[7:6] != 2'b11)

endmodule

bind utf16_to_utf8_encoder_top u16u8_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .unit_valid (unit_valid),
  .unit_stall (unit_stall),
  .code_unit  (code_unit),
  .last_unit  (last_unit),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .out_byte   (out_byte),
  .run_end    (run_end),
  .string_end (string_end)
);
`default_nettype wire
